/* design/ece_pkg.sv */
// Shared types, constants and elaboration-time tables for the easing curve evaluator.
`default_nettype none

package ece_pkg;

    // Fixed-point formats of the ports and of the inner Q31 datapath.
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam int TDATA_W   = ((VAL_W + 7) / 8) * 8;
    localparam int QBITS     = 31;
    localparam logic [31:0] QONE  = 32'h8000_0000;
    localparam logic [31:0] QHALF = 32'h4000_0000;
    localparam logic [VAL_W-1:0] ONE_P = VAL_W'(1) << FRAC_BITS;

    // Sine quarter-wave table.
    localparam int SINE_DEPTH     = 256;
    localparam int SINE_ADDR_BITS = 8;
    localparam int SINE_IDX_W     = SINE_ADDR_BITS + 1;
    localparam logic [63:0] QPI_HALF = 64'd3373259426;
    localparam int TAYLOR_LAST    = 21;

    // Power-of-two fraction table and square root unit.
    localparam int EXP_STEPS            = 24;
    localparam int SQRT_ITERS           = 32;
    localparam int SQRT_STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES          = SQRT_ITERS / SQRT_STEPS_PER_STAGE;

    // Input queue between the front and back ends.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Configuration register indexes.
    localparam logic CFG_FAMILY    = 1'b0;
    localparam logic CFG_DIRECTION = 1'b1;

    // Direction register codes; the unused code behaves as in-out.
    localparam logic [1:0] DIR_IN    = 2'd0;
    localparam logic [1:0] DIR_OUT   = 2'd1;
    localparam logic [1:0] DIR_INOUT = 2'd2;

    typedef enum logic [2:0] {
        FAM_LINEAR,
        FAM_QUAD,
        FAM_CUBIC,
        FAM_QUARTIC,
        FAM_QUINTIC,
        FAM_SINE,
        FAM_CIRCULAR,
        FAM_EXP
    } family_t;

    // How the ease-in value is folded into the final curve.
    typedef enum logic [1:0] {
        MODE_IN,
        MODE_OUT,
        MODE_IO_LO,
        MODE_IO_HI
    } mode_t;

    // Per-word control that travels the whole back end.
    typedef struct packed {
        family_t          fam;
        mode_t            mode;
        logic             clamped;
        logic [VAL_W-1:0] prog;
    } ctrl_t;

    // Queue entry: classified word with its ease-in argument in Q31.
    typedef struct packed {
        ctrl_t       ctrl;
        logic [31:0] x;
    } item_t;

    // Multiplier chain stage contents.
    typedef struct packed {
        ctrl_t                ctrl;
        logic [31:0]          x;
        logic [31:0]          acc;
        logic [31:0]          opnd;
        logic                 use0;
        logic [31:0]          lo;
        logic [EXP_STEPS-1:0] ebits;
        logic [3:0]           sh;
        logic                 ezero;
    } chain_t;

    // Side data carried alongside the square root unit.
    typedef struct packed {
        ctrl_t       ctrl;
        logic [31:0] acc;
        logic [31:0] lo;
        logic [3:0]  sh;
        logic        ezero;
    } tag_t;

    typedef logic [31:0] sine_tab_t [SINE_DEPTH+1];
    typedef logic [31:0] exp_tab_t [EXP_STEPS];

    // Rounded Q31 product, used only while building tables.
    function automatic logic [63:0] mulq_c(input logic [63:0] a, input logic [63:0] b);
        return (a * b + 64'(QHALF)) >> QBITS;
    endfunction

    // Digit-by-digit square root rounded to nearest, used only while building tables.
    function automatic logic [63:0] isqrt_c(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bits;
        n   = n_in;
        res = 64'd0;
        for (int i = 0; i < SQRT_ITERS; i++) begin
            bits = 64'd1 << (62 - 2 * i);
            if (n >= res + bits) begin
                n   = n - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
        end
        if (n > res) begin
            res = res + 64'd1;
        end
        return res;
    endfunction

    // Sine points by Taylor series, clamped to 1.0.
    function automatic sine_tab_t build_sine();
        sine_tab_t   tab;
        logic [63:0] a;
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] v;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            a   = (QPI_HALF * 64'(k) + 64'(SINE_DEPTH / 2)) / 64'(SINE_DEPTH);
            t   = a;
            pos = 64'd0;
            neg = 64'd0;
            for (int n = 1; n <= TAYLOR_LAST; n += 2) begin
                if (((n >> 1) & 1) == 1) begin
                    neg = neg + t;
                end else begin
                    pos = pos + t;
                end
                t = mulq_c(mulq_c(t, a), a) / 64'((n + 1) * (n + 2));
            end
            v = (pos >= neg) ? pos - neg : 64'd0;
            tab[k] = (v > 64'(QONE)) ? QONE : v[31:0];
        end
        return tab;
    endfunction

    // Entries 2^(-2^-(i+1)) by repeated square roots of one half.
    function automatic exp_tab_t build_exp();
        exp_tab_t    tab;
        logic [63:0] cur;
        cur    = isqrt_c(64'(QHALF) << QBITS);
        tab[0] = cur[31:0];
        for (int i = 1; i < EXP_STEPS; i++) begin
            cur    = isqrt_c(64'(tab[i-1]) << QBITS);
            tab[i] = cur[31:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();
    localparam exp_tab_t  EXP_TAB  = build_exp();

endpackage

`default_nettype wire

/* design/ece_front.sv */
// Front end: configuration registers, input clamp and curve classification.
`default_nettype none

module ece_front
    import ece_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_addr,
    input  wire logic [2:0]         cfg_wdata,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,
    input  wire logic               q_full,
    output logic                    q_push,
    output item_t                   q_item
);

    family_t    family_reg;
    logic [1:0] direction_reg;

    logic [VAL_W-1:0] prog;
    logic [VAL_W-1:0] prog_clamped;
    logic             clamped;
    logic [31:0]      p31;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            family_reg    <= FAM_LINEAR;
            direction_reg <= DIR_IN;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FAMILY:    family_reg    <= family_t'(cfg_wdata);
                CFG_DIRECTION: direction_reg <= cfg_wdata[1:0];
                default:       family_reg    <= family_reg;
            endcase
        end
    end

    // Clamp progress to 1.0 and widen it to Q31.
    assign prog         = s_tdata[VAL_W-1:0];
    assign clamped      = prog > ONE_P;
    assign prog_clamped = clamped ? ONE_P : prog;
    assign p31          = 32'(prog_clamped) << (QBITS - FRAC_BITS);

    // Fold the direction into one ease-in argument and a mode.
    always_comb begin
        q_item.ctrl.fam     = family_reg;
        q_item.ctrl.clamped = clamped;
        q_item.ctrl.prog    = prog_clamped;
        case (direction_reg)
            DIR_IN: begin
                q_item.ctrl.mode = MODE_IN;
                q_item.x         = p31;
            end
            DIR_OUT: begin
                q_item.ctrl.mode = MODE_OUT;
                q_item.x         = QONE - p31;
            end
            default: begin
                if (p31 < QHALF) begin
                    q_item.ctrl.mode = MODE_IO_LO;
                    q_item.x         = p31 << 1;
                end else begin
                    q_item.ctrl.mode = MODE_IO_HI;
                    q_item.x         = (QONE - p31) << 1;
                end
            end
        endcase
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

`default_nettype wire

/* design/ece_queue.sv */
// Short queue that decouples the front end from the back-end pipeline.
`default_nettype none

module ece_queue
    import ece_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  item_t     push_item,
    output logic      full,
    input  wire logic pop,
    output logic      head_vld,
    output item_t     head_item
);

    item_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full      = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign head_vld  = count_reg != '0;
    assign head_item = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

    // Word storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop)) else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0) else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

/* design/ece_sqrt.sv */
// Pipelined digit-by-digit square root, rounded to nearest, with side data.
`default_nettype none

module ece_sqrt
    import ece_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        adv,
    input  wire logic        in_vld,
    input  wire logic [63:0] in_n,
    input  tag_t             in_tag,
    output logic             out_vld,
    output logic [31:0]      out_root,
    output tag_t             out_tag
);

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] res;
    } sq_t;

    sq_t  st_reg   [SQRT_STAGES];
    sq_t  st_next  [SQRT_STAGES];
    tag_t tag_reg  [SQRT_STAGES];
    logic vld_reg  [SQRT_STAGES];

    logic [31:0] out_root_reg;
    tag_t        out_tag_reg;
    logic        out_vld_reg;

    // Two root digits per stage.
    function automatic sq_t sqrt_step(input sq_t s, input int stage);
        sq_t         r;
        logic [63:0] bits;
        r = s;
        for (int k = 0; k < SQRT_STEPS_PER_STAGE; k++) begin
            bits = 64'd1 << (62 - 2 * (stage * SQRT_STEPS_PER_STAGE + k));
            if (r.n >= r.res + bits) begin
                r.n   = r.n - (r.res + bits);
                r.res = (r.res >> 1) + bits;
            end else begin
                r.res = r.res >> 1;
            end
        end
        return r;
    endfunction

    assign st_next[0] = sqrt_step('{n: in_n, res: 64'd0}, 0);

    for (genvar j = 1; j < SQRT_STAGES; j++) begin : g_step
        assign st_next[j] = sqrt_step(st_reg[j-1], j);
    end

    // Stage registers and the final rounding register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < SQRT_STAGES; j++) begin
                vld_reg[j] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_vld;
            st_reg[0]  <= st_next[0];
            tag_reg[0] <= in_tag;
            for (int j = 1; j < SQRT_STAGES; j++) begin
                vld_reg[j] <= vld_reg[j-1];
                st_reg[j]  <= st_next[j];
                tag_reg[j] <= tag_reg[j-1];
            end
            out_vld_reg  <= vld_reg[SQRT_STAGES-1];
            out_tag_reg  <= tag_reg[SQRT_STAGES-1];
            out_root_reg <= st_reg[SQRT_STAGES-1].res[31:0]
                + 32'(st_reg[SQRT_STAGES-1].n > st_reg[SQRT_STAGES-1].res);
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_root = out_root_reg;
    assign out_tag  = out_tag_reg;

`ifndef SYNTHESIS
    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> out_root_reg <= QONE) else $error("root above one");
`endif

endmodule

`default_nettype wire

/* design/ece_back.sv */
// Back end: table lookups, shared multiplier chain, square root and output register.
`default_nettype none

module ece_back
    import ece_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_vld,
    input  item_t           q_item,
    output logic            q_pop,
    input  wire logic       m_tready,
    output logic            m_vld,
    output logic [VAL_W-1:0] m_value,
    output logic            m_clamped
);

    logic adv;

    item_t  s0_reg;
    logic   s0_vld_reg;
    chain_t prep_next;

    chain_t chain_reg     [EXP_STEPS+1];
    chain_t chain_next    [EXP_STEPS+1];
    logic   chain_vld_reg [EXP_STEPS+1];

    logic [63:0] sqrt_n;
    logic [31:0] sq_clamped;
    tag_t        sqrt_tag;
    logic        sqrt_vld;
    logic [31:0] sqrt_root;
    tag_t        sqrt_out_tag;

    logic [31:0] f_next;
    logic [31:0] f_reg;
    ctrl_t       f_ctrl_reg;
    logic        f_vld_reg;

    logic [32:0]       v;
    logic [32:0]       v_rnd;
    logic [VAL_W-1:0]  value_next;
    logic [VAL_W-1:0]  out_value_reg;
    logic              out_clamped_reg;
    logic              out_vld_reg;

    // Every stage moves together unless a result is waiting.
    assign adv   = !out_vld_reg || m_tready;
    assign q_pop = adv && q_vld;

    // Sine lookup, exponent split and operands of the first multiplier.
    always_comb begin
        logic [31:0]           y;
        logic [SINE_IDX_W-1:0] k;
        logic [30:0]           frac;
        logic [31:0]           hi;
        logic [31:0]           diff;
        logic [34:0]           e;
        y    = QONE - s0_reg.x;
        k    = y[31:QBITS-SINE_ADDR_BITS];
        frac = {y[QBITS-SINE_ADDR_BITS-1:0], SINE_ADDR_BITS'(0)};
        if (k >= SINE_IDX_W'(SINE_DEPTH)) begin
            prep_next.lo = SINE_TAB[SINE_DEPTH];
            hi           = SINE_TAB[SINE_DEPTH];
            diff         = 32'd0;
        end else begin
            prep_next.lo = SINE_TAB[k];
            hi           = SINE_TAB[k + SINE_IDX_W'(1)];
            diff         = (hi >= prep_next.lo) ? hi - prep_next.lo : 32'd0;
        end
        e = {y, 3'b000} + {2'b00, y, 1'b0};
        prep_next.ctrl  = s0_reg.ctrl;
        prep_next.x     = s0_reg.x;
        prep_next.sh    = e[34:31];
        prep_next.ebits = e[30:31-EXP_STEPS];
        prep_next.ezero = s0_reg.x == 32'd0;
        case (s0_reg.ctrl.fam)
            FAM_SINE: begin
                prep_next.acc  = diff;
                prep_next.opnd = {1'b0, frac};
                prep_next.use0 = 1'b1;
            end
            FAM_EXP: begin
                prep_next.acc  = QONE;
                prep_next.opnd = EXP_TAB[0];
                prep_next.use0 = e[30];
            end
            default: begin
                prep_next.acc  = s0_reg.x;
                prep_next.opnd = s0_reg.x;
                prep_next.use0 = s0_reg.ctrl.fam != FAM_LINEAR;
            end
        endcase
    end

    // One rounded Q31 product per chain stage, applied when the family needs it.
    function automatic chain_t chain_step(input chain_t c, input int stage);
        chain_t      r;
        logic        use_m;
        logic [31:0] opnd;
        logic [63:0] prod;
        r = c;
        if (stage == 0) begin
            use_m = c.use0;
            opnd  = c.opnd;
        end else if (c.ctrl.fam == FAM_EXP) begin
            use_m = c.ebits[EXP_STEPS-1-stage];
            opnd  = EXP_TAB[stage];
        end else begin
            use_m = (c.ctrl.fam != FAM_LINEAR) && (c.ctrl.fam != FAM_SINE)
                && (c.ctrl.fam != FAM_CIRCULAR) && (int'(c.ctrl.fam) > stage);
            opnd  = c.x;
        end
        prod = 64'(c.acc) * 64'(opnd) + 64'(QHALF);
        if (use_m) begin
            r.acc = prod[62:31];
        end
        return r;
    endfunction

    assign chain_next[0] = prep_next;
    for (genvar i = 0; i < EXP_STEPS; i++) begin : g_chain
        assign chain_next[i+1] = chain_step(chain_reg[i], i);
    end

    // Input stage and multiplier chain registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
            for (int i = 0; i <= EXP_STEPS; i++) begin
                chain_vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            s0_vld_reg       <= q_vld;
            s0_reg           <= q_item;
            chain_vld_reg[0] <= s0_vld_reg;
            chain_reg[0]     <= chain_next[0];
            for (int i = 1; i <= EXP_STEPS; i++) begin
                chain_vld_reg[i] <= chain_vld_reg[i-1];
                chain_reg[i]     <= chain_next[i];
            end
        end
    end

    // Circular curve: root of one minus the square.
    assign sq_clamped = (chain_reg[EXP_STEPS].acc > QONE) ? QONE : chain_reg[EXP_STEPS].acc;
    assign sqrt_n     = 64'(QONE - sq_clamped) << QBITS;
    assign sqrt_tag   = '{ctrl:  chain_reg[EXP_STEPS].ctrl,
                          acc:   chain_reg[EXP_STEPS].acc,
                          lo:    chain_reg[EXP_STEPS].lo,
                          sh:    chain_reg[EXP_STEPS].sh,
                          ezero: chain_reg[EXP_STEPS].ezero};

    ece_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_vld   (chain_vld_reg[EXP_STEPS]),
        .in_n     (sqrt_n),
        .in_tag   (sqrt_tag),
        .out_vld  (sqrt_vld),
        .out_root (sqrt_root),
        .out_tag  (sqrt_out_tag)
    );

    // Ease-in value for each family.
    always_comb begin
        logic [32:0] rnd;
        logic [32:0] shv;
        rnd = (sqrt_out_tag.sh == 4'd0) ? 33'd0 : (33'd1 << (sqrt_out_tag.sh - 4'd1));
        shv = ({1'b0, sqrt_out_tag.acc} + rnd) >> sqrt_out_tag.sh;
        case (sqrt_out_tag.ctrl.fam)
            FAM_SINE:     f_next = QONE - (sqrt_out_tag.lo + sqrt_out_tag.acc);
            FAM_CIRCULAR: f_next = QONE - sqrt_root;
            FAM_EXP:      f_next = sqrt_out_tag.ezero ? 32'd0 : shv[31:0];
            default:      f_next = sqrt_out_tag.acc;
        endcase
    end

    // Fold into the chosen direction and round to the output format.
    always_comb begin
        case (f_ctrl_reg.mode)
            MODE_IN:    v = {f_reg, 1'b0};
            MODE_OUT:   v = {QONE - f_reg, 1'b0};
            MODE_IO_LO: v = {1'b0, f_reg};
            default:    v = {QONE, 1'b0} - {1'b0, f_reg};
        endcase
        v_rnd = v + (33'd1 << (QBITS - FRAC_BITS));
        if (f_ctrl_reg.fam == FAM_LINEAR) begin
            value_next = f_ctrl_reg.prog;
        end else begin
            value_next = v_rnd[32:32-FRAC_BITS];
        end
    end

    // Curve value register and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            f_vld_reg       <= sqrt_vld;
            f_reg           <= f_next;
            f_ctrl_reg      <= sqrt_out_tag.ctrl;
            out_vld_reg     <= f_vld_reg;
            out_value_reg   <= value_next;
            out_clamped_reg <= f_ctrl_reg.clamped;
        end
    end

    assign m_vld     = out_vld_reg;
    assign m_value   = out_value_reg;
    assign m_clamped = out_clamped_reg;

`ifndef SYNTHESIS
    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> out_value_reg <= ONE_P) else $error("eased value above one");
`endif

endmodule

`default_nettype wire

/* design/easing_curve_evaluator.sv */
// Top level of the easing curve evaluator: front end, queue and back-end pipeline.
//
//   Channel  Ports              Word contents (lowest bit first)
//   input    s_tvalid/tready    s_tdata: progress[16:0], zero fill to 24 bits
//   result   m_tvalid/tready    m_tdata: eased_value[16:0], zero fill; m_tuser: progress_clamped
//   config   cfg_wr_en          cfg_addr 0 curve_family, 1 curve_direction; cfg_wdata
//
// One word is taken per cycle and one result leaves per cycle when nothing stalls.
// From the queue, words pass the input stage, the 24-stage multiplier chain of the
// exponential curves, the square root of the circular curve and the output registers.
// Reset is synchronous and active low; it clears configuration and all valid flags.
// A stalled output freezes the back end; the four-word queue keeps taking input
// until it fills, and then the input stalls as well.
`default_nettype none

module easing_curve_evaluator
    import ece_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_addr,
    input  wire logic [2:0]         cfg_wdata,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // progress
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // eased_value
    output logic                    m_tuser    // progress_clamped
);

    logic             q_full;
    logic             q_push;
    item_t            q_item;
    logic             q_pop;
    logic             q_vld;
    item_t            q_head;
    logic [VAL_W-1:0] value;

    ece_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    ece_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_vld  (q_vld),
        .head_item (q_head)
    );

    ece_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_vld     (q_vld),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .m_tready  (m_tready),
        .m_vld     (m_tvalid),
        .m_value   (value),
        .m_clamped (m_tuser)
    );

    assign m_tdata = TDATA_W'(value);

endmodule

`default_nettype wire
